// File: src/tc_pkg.sv
// tc_pkg: shared types and constants for the threshold_centroid block
// no dependencies

package tc_pkg;

   localparam int SUM_W      = 19;
   localparam int CNT_W      = 13;
   localparam int CENTRE_W   = 14;
   localparam int GRAY_W     = 8;
   localparam int ROWW_W     = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0]    COUNT_MAX  = {CNT_W{1'b1}};
   localparam logic [CENTRE_W-1:0] CENTRE_MAX = {CENTRE_W{1'b1}};

   localparam logic [GRAY_W-1:0] THRESHOLD_RESET = 8'd50;
   localparam logic [ROWW_W-1:0] ROW_WIDTH_RESET = 7'd12;

   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH      = 4'd1;

   typedef struct packed {
      logic [SUM_W-1:0] column_sum;
      logic [SUM_W-1:0] row_sum;
      logic [CNT_W-1:0] dark_count;
   } tc_snap_type;

   typedef struct packed {
      logic        valid;
      tc_snap_type snap;
   } tc_push_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_DONE
   } tc_back_state_type;

endpackage

// File: src/tc_front.sv
// tc_front: pixel intake, dark classification and per-frame moment sums
// uses tc_pkg; pushes one snapshot per frame toward tc_queue

module tc_front import tc_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [GRAY_W-1:0] gray_level,
   input  logic              frame_end,
   input  logic [GRAY_W-1:0] dark_threshold,
   input  logic [ROWW_W-1:0] row_width,
   output tc_push_type       push
);

   localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > ROWW_W) ? $clog2(MAX_WIDTH + 1) : ROWW_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] xsum_ff, xsum_in;
   logic [SUM_W-1:0] ysum_ff, ysum_in;

   logic [WCMP_W-1:0] rw_ext, max_w, wid, col_inc;
   logic [ROW_W:0]    row_inc;
   logic [SUM_W:0]    xadd, yadd;
   logic              dark, wrap, row_adv;

   always_comb begin
      rw_ext  = WCMP_W'(row_width);
      max_w   = WCMP_W'(MAX_WIDTH);
      if (rw_ext == '0) begin
         wid = WCMP_W'(1);
      end else if (rw_ext > max_w) begin
         wid = max_w;
      end else begin
         wid = rw_ext;
      end
      col_inc = WCMP_W'(col_ff) + WCMP_W'(1);
      row_inc = {1'b0, row_ff} + (ROW_W+1)'(1);
      wrap    = (col_inc >= wid);
      row_adv = (row_inc < (ROW_W+1)'(MAX_HEIGHT));
      dark    = (gray_level <= dark_threshold);

      xadd = {1'b0, xsum_ff} + (SUM_W+1)'(col_inc);
      yadd = {1'b0, ysum_ff} + (SUM_W+1)'(row_inc);

      xsum_in  = xsum_ff;
      ysum_in  = ysum_ff;
      count_in = count_ff;
      if (dark) begin
         xsum_in  = xadd[SUM_W] ? SUM_MAX : xadd[SUM_W-1:0];
         ysum_in  = yadd[SUM_W] ? SUM_MAX : yadd[SUM_W-1:0];
         count_in = (count_ff == COUNT_MAX) ? COUNT_MAX : count_ff + CNT_W'(1);
      end

      col_in = wrap ? '0 : COL_W'(col_inc);
      row_in = (wrap && row_adv) ? ROW_W'(row_inc) : row_ff;

      push.valid           = accept && frame_end;
      push.snap.column_sum = xsum_in;
      push.snap.row_sum    = ysum_in;
      push.snap.dark_count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         count_ff <= '0;
         xsum_ff  <= '0;
         ysum_ff  <= '0;
      end else if (accept) begin
         if (frame_end) begin
            col_ff   <= '0;
            row_ff   <= '0;
            count_ff <= '0;
            xsum_ff  <= '0;
            ysum_ff  <= '0;
         end else begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            count_ff <= count_in;
            xsum_ff  <= xsum_in;
            ysum_ff  <= ysum_in;
         end
      end
   end

endmodule

// File: src/tc_queue.sv
// tc_queue: two-entry queue of frame snapshots between front and back
// uses tc_pkg

module tc_queue import tc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  tc_push_type push,
   input  logic        pop,
   output logic        full,
   output logic        q_valid,
   output tc_snap_type q_data
);

   tc_snap_type mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push.valid, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push.valid)
      else $error("snapshot pushed into a full queue");

endmodule

// File: src/tc_back.sv
// tc_back: two restoring dividers that turn moment sums into fixed-point means
// uses tc_pkg; pops tc_queue and owns the result output register

module tc_back import tc_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  tc_snap_type         q_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CENTRE_W-1:0] rsp_centre_x,
   output logic [CENTRE_W-1:0] rsp_centre_y,
   output logic [CNT_W-1:0]    rsp_dark_total,
   output logic                rsp_frame_empty
);

   localparam int DIV_W  = SUM_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DIV_W);

   tc_back_state_type state_ff, state_in;

   logic [DIV_W-1:0]  accx_ff, accy_ff, accx_in, accy_in;
   logic [CNT_W-1:0]  remx_ff, remy_ff, remx_in, remy_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CNT_W:0]    shx, shy;
   logic              gex, gey, last_step, out_free, out_load, dividing;
   logic [CENTRE_W-1:0] qx, qy;

   logic                rsp_valid_ff;
   logic [CENTRE_W-1:0] cx_ff, cy_ff;
   logic [CNT_W-1:0]    total_ff;
   logic                empty_ff;

   assign last_step = (step_ff == STEP_W'(DIV_W - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (q_valid) state_in = BK_DIVIDE;
         BK_DIVIDE: if (last_step) state_in = BK_DONE;
         BK_DONE:   if (out_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop      = (state_ff == BK_IDLE) && q_valid;
      dividing = (state_ff == BK_DIVIDE);
      out_load = (state_ff == BK_DONE) && out_free;
   end

   always_comb begin
      shx     = {remx_ff, accx_ff[DIV_W-1]};
      shy     = {remy_ff, accy_ff[DIV_W-1]};
      gex     = (shx >= {1'b0, cnt_ff});
      gey     = (shy >= {1'b0, cnt_ff});
      remx_in = gex ? CNT_W'(shx - {1'b0, cnt_ff}) : CNT_W'(shx);
      remy_in = gey ? CNT_W'(shy - {1'b0, cnt_ff}) : CNT_W'(shy);
      accx_in = {accx_ff[DIV_W-2:0], gex};
      accy_in = {accy_ff[DIV_W-2:0], gey};
      qx = (|accx_ff[DIV_W-1:CENTRE_W]) ? CENTRE_MAX : accx_ff[CENTRE_W-1:0];
      qy = (|accy_ff[DIV_W-1:CENTRE_W]) ? CENTRE_MAX : accy_ff[CENTRE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         accx_ff <= DIV_W'(q_data.column_sum) << FRAC_BITS;
         accy_ff <= DIV_W'(q_data.row_sum) << FRAC_BITS;
         remx_ff <= '0;
         remy_ff <= '0;
         cnt_ff  <= q_data.dark_count;
         step_ff <= '0;
      end else if (dividing) begin
         accx_ff <= accx_in;
         accy_ff <= accy_in;
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (cnt_ff == '0) begin
            cx_ff    <= '0;
            cy_ff    <= '0;
            total_ff <= '0;
            empty_ff <= 1'b1;
         end else begin
            cx_ff    <= qx;
            cy_ff    <= qy;
            total_ff <= cnt_ff;
            empty_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centre_x    = cx_ff;
   assign rsp_centre_y    = cy_ff;
   assign rsp_dark_total  = total_ff;
   assign rsp_frame_empty = empty_ff;

   assert property (@(posedge clock) disable iff (reset) pop |=> state_ff == BK_DIVIDE)
      else $error("popped snapshot did not start a division");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_frame_empty) |->
         (rsp_centre_x == '0 && rsp_centre_y == '0 && rsp_dark_total == '0))
      else $error("empty frame with nonzero result fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_frame_empty) |-> rsp_dark_total != '0)
      else $error("nonempty frame with zero dark count");

endmodule

// File: src/threshold_centroid.sv
// threshold_centroid: top level, configuration registers and block wiring
// uses tc_pkg, tc_front, tc_queue, tc_back
//
// Centroid of the dark pixels of a gray frame. Pixels enter in raster order
// at one per cycle; req_stall rises only while two finished frames wait in
// the snapshot queue. Each frame result is produced by two restoring dividers
// working in parallel, one quotient bit per cycle; the result of a frame
// passes from the queue through BK_DIVIDE and BK_DONE into the result register once
// the output is free, and frames shorter than the division back up through the queue into req_stall.

module threshold_centroid import tc_pkg::*; #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int FRAC_BITS  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [GRAY_W-1:0]     req_gray_level,
   input  logic                  req_frame_end,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CENTRE_W-1:0]   rsp_centre_x,
   output logic [CENTRE_W-1:0]   rsp_centre_y,
   output logic [CNT_W-1:0]      rsp_dark_total,
   output logic                  rsp_frame_empty,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [GRAY_W-1:0] threshold_ff;
   logic [ROWW_W-1:0] row_width_ff;
   logic              accept, q_full, q_valid, pop;
   tc_push_type       push;
   tc_snap_type       q_data;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         row_width_ff <= ROW_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DARK_THRESHOLD: threshold_ff <= csr_data;
            CSR_ROW_WIDTH:      row_width_ff <= csr_data[ROWW_W-1:0];
            default:            threshold_ff <= threshold_ff;
         endcase
      end
   end

   tc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .gray_level     (req_gray_level),
      .frame_end      (req_frame_end),
      .dark_threshold (threshold_ff),
      .row_width      (row_width_ff),
      .push           (push)
   );

   tc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .full    (q_full),
      .q_valid (q_valid),
      .q_data  (q_data)
   );

   tc_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_centre_x    (rsp_centre_x),
      .rsp_centre_y    (rsp_centre_y),
      .rsp_dark_total  (rsp_dark_total),
      .rsp_frame_empty (rsp_frame_empty)
   );

endmodule

// File: sim/tb_threshold_centroid.sv
// tb_threshold_centroid: self-checking testbench for the threshold_centroid block
// depends on tc_pkg and threshold_centroid; a scoreboard class predicts every frame result
// directed frames cover the edge cases, then random phases with random handshake gaps

module tb_threshold_centroid import tc_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W        = 64;
   localparam int MAX_H        = 64;
   localparam int FRAC         = 8;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_FRAME   = 90;
   localparam int PHASE_ITEMS  = 50;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 4'd9;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 4'd6;

   typedef struct {
      logic [CENTRE_W-1:0] centre_x;
      logic [CENTRE_W-1:0] centre_y;
      logic [CNT_W-1:0]    dark_total;
      logic                frame_empty;
   } frame_centroid_type;

   class centroid_scoreboard;
      logic [GRAY_W-1:0]  threshold;
      logic [ROWW_W-1:0]  row_width;
      int unsigned        col_pos, row_pos, dark_count, col_sum, row_sum;
      frame_centroid_type pending[$];
      int                 errors;

      function new();
         threshold = THRESHOLD_RESET;
         row_width = ROW_WIDTH_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         col_pos = 0;
         row_pos = 0;
         dark_count = 0;
         col_sum = 0;
         row_sum = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_DARK_THRESHOLD) begin
            threshold = data[GRAY_W-1:0];
         end else if (idx == CSR_ROW_WIDTH) begin
            row_width = data[ROWW_W-1:0];
         end
      endfunction

      function int unsigned capped_add(int unsigned a, int unsigned b, int unsigned cap);
         return (a + b > cap) ? cap : a + b;
      endfunction

      function logic [CENTRE_W-1:0] fixed_mean(int unsigned sum, int unsigned n);
         longint unsigned wide;
         longint unsigned q;
         wide = sum;
         q = (wide << FRAC) / n;
         return (q > CENTRE_MAX) ? CENTRE_MAX : q[CENTRE_W-1:0];
      endfunction

      function void note_pixel(logic [GRAY_W-1:0] gray, logic last);
         int unsigned        span;
         frame_centroid_type r;
         span = row_width;
         if (span < 1) span = 1;
         if (span > MAX_W) span = MAX_W;
         if (gray <= threshold) begin
            dark_count = capped_add(dark_count, 1, COUNT_MAX);
            col_sum = capped_add(col_sum, col_pos + 1, SUM_MAX);
            row_sum = capped_add(row_sum, row_pos + 1, SUM_MAX);
         end
         if (col_pos + 1 >= span) begin
            col_pos = 0;
            if (row_pos + 1 < MAX_H) row_pos++;
         end else begin
            col_pos++;
         end
         if (last) begin
            if (dark_count == 0) begin
               r.centre_x = '0;
               r.centre_y = '0;
               r.dark_total = '0;
               r.frame_empty = 1'b1;
            end else begin
               r.centre_x = fixed_mean(col_sum, dark_count);
               r.centre_y = fixed_mean(row_sum, dark_count);
               r.dark_total = dark_count[CNT_W-1:0];
               r.frame_empty = 1'b0;
            end
            pending.push_back(r);
            clear_frame();
         end
      endfunction

      task report_mismatch(string what, int got, int want);
         errors++;
         if (errors <= 20) $display("mismatch %s: got %0d want %0d", what, got, want);
      endtask

      task check_centroid(logic [CENTRE_W-1:0] cx, logic [CENTRE_W-1:0] cy,
                          logic [CNT_W-1:0] total, logic empty);
         frame_centroid_type want;
         if (pending.size() == 0) begin
            report_mismatch("unexpected transaction", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (cx !== want.centre_x) report_mismatch("centre_x", cx, want.centre_x);
         if (cy !== want.centre_y) report_mismatch("centre_y", cy, want.centre_y);
         if (total !== want.dark_total) report_mismatch("dark_total", total, want.dark_total);
         if (empty !== want.frame_empty)
            report_mismatch("frame_empty", empty, want.frame_empty);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [GRAY_W-1:0]     req_gray_level = '0;
   logic                  req_frame_end = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CENTRE_W-1:0]   rsp_centre_x;
   logic [CENTRE_W-1:0]   rsp_centre_y;
   logic [CNT_W-1:0]      rsp_dark_total;
   logic                  rsp_frame_empty;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   centroid_scoreboard sb = new();
   int cycle_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;

   threshold_centroid #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H),
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_gray_level(req_gray_level),
      .req_frame_end(req_frame_end),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_centre_x(rsp_centre_x),
      .rsp_centre_y(rsp_centre_y),
      .rsp_dark_total(rsp_dark_total),
      .rsp_frame_empty(rsp_frame_empty),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stall pattern, with a new random mode each time its countdown runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[2];
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
         if (req_valid && !req_stall) sb.note_pixel(req_gray_level, req_frame_end);
         if (rsp_valid && !rsp_stall)
            sb.check_centroid(rsp_centre_x, rsp_centre_y, rsp_dark_total, rsp_frame_empty);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [GRAY_W-1:0] gray, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_gray_level <= gray;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // all results back and the block quiet before touching the registers
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int                k, len, sent, phase;
      logic [GRAY_W-1:0] thr;
      logic [GRAY_W-1:0] g;
      logic [CSR_DATA_W-1:0] wval;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register reset values: empty frame, single dark pixel, threshold boundary
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd50, 1'b0);
      send_pixel(8'd51, 1'b0);
      send_pixel(8'd170, 1'b0);
      send_pixel(8'd85, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd49, 1'b1);
      settle();

      // mean column of exactly 64 saturates
      write_csr(CSR_DARK_THRESHOLD, 8'd0);
      write_csr(CSR_ROW_WIDTH, 8'd64);
      for (k = 0; k < 63; k++) send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b1);
      settle();

      // zero row width acts as one, rows run past the last one
      write_csr(CSR_DARK_THRESHOLD, 8'd255);
      write_csr(CSR_ROW_WIDTH, 8'd0);
      for (k = 0; k < 70; k++) send_pixel(8'd255, k == 69);
      settle();

      // unused indexes, oversize width acts as the widest row
      write_csr(CSR_UNUSED_A, 8'hAA);
      write_csr(CSR_UNUSED_B, 8'h55);
      write_csr(CSR_ROW_WIDTH, 8'hC8);
      write_csr(CSR_DARK_THRESHOLD, 8'd0);
      for (k = 0; k < LONG_FRAME; k++) send_pixel(8'd0, k == LONG_FRAME - 1);
      settle();

      write_csr(CSR_ROW_WIDTH, 8'h7F);
      write_csr(CSR_DARK_THRESHOLD, 8'd1);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd2, 1'b0);
      send_pixel(8'd0, 1'b1);
      settle();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: thr = 8'd0;
            1: thr = 8'd255;
            default: thr = GRAY_W'($urandom_range(0, 255));
         endcase
         case (phase)
            0: wval = 8'd1;
            1: wval = 8'd64;
            2: wval = 8'd0;
            3: wval = CSR_DATA_W'($urandom_range(65, 255));
            4: wval = CSR_DATA_W'($urandom_range(1, 64));
            default: wval = CSR_DATA_W'($urandom_range(2, 63));
         endcase
         write_csr(CSR_DARK_THRESHOLD, thr);
         write_csr(CSR_ROW_WIDTH, wval);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
            for (k = 0; k < len; k++) begin
               case ($urandom_range(0, 3))
                  0, 1: g = GRAY_W'($urandom_range(0, 255));
                  2: g = GRAY_W'(thr + $urandom_range(0, 2) - 1);
                  default: g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               endcase
               send_pixel(g, k == len - 1);
            end
            sent += len;
         end
         settle();
      end

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
